// ===== design/luhn_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// luhn_pkg
// Shared types, constants and the double-dabble bit function for the Luhn checker.
// ----------------------------------------------------------------------------
package luhn_pkg;

    // Field widths
    localparam int unsigned CARD_W        = 63;
    localparam int unsigned COUNT_W       = 5;
    localparam int unsigned BRAND_W       = 2;
    localparam int unsigned DIGIT_W       = 4;

    // Conversion sizing: card padded to 64 bits, 4 bits folded in per cycle
    localparam int unsigned BIN_W         = 64;
    localparam int unsigned BITS_PER_STEP = 4;
    localparam int unsigned CONV_STEPS    = BIN_W / BITS_PER_STEP;
    localparam int unsigned STEP_CNT_W    = $clog2(CONV_STEPS);
    localparam int unsigned NUM_DIGITS    = 19;
    localparam int unsigned BCD_W         = NUM_DIGITS * DIGIT_W;

    // Brand codes
    localparam logic [BRAND_W-1:0] BRAND_NONE   = 2'd0;
    localparam logic [BRAND_W-1:0] BRAND_FOUR   = 2'd1;
    localparam logic [BRAND_W-1:0] BRAND_FIFTY  = 2'd2;
    localparam logic [BRAND_W-1:0] BRAND_THIRTY = 2'd3;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_SCAN,
        S_CLASS
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;   // capture card number, clear accumulators
        logic conv;   // one double-dabble step of BITS_PER_STEP bits
        logic scan;   // consume lowest BCD digit
        logic emit;   // load result register
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic bcd_zero;  // no digits left to scan
    } t_dp_status;

    // One double-dabble bit: add 3 to every digit of 5 or more, then shift in one binary bit
    function automatic logic [BCD_W-1:0] dabble_bit(input logic [BCD_W-1:0] bcd,
                                                    input logic             b);
        logic [BCD_W-1:0]   adj;
        logic [DIGIT_W-1:0] dig;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            dig = bcd[DIGIT_W*i +: DIGIT_W];
            adj[DIGIT_W*i +: DIGIT_W] = (dig >= 4'd5) ? dig + 4'd3 : dig;
        end
        return {adj[BCD_W-2:0], b};
    endfunction

endpackage

// ===== design/luhn_card_number_check_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// luhn_card_number_check_top
// Luhn mod-10 card number checker with digit count and brand code.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_in_valid / o_in_ready carries a 63-bit card number.
//   Output channel o_out_valid / i_out_ready returns brand, luhn_ok and
//   digit_count, one result transaction per input transaction.
// Sequence:
//   After acceptance the number is turned into BCD by double-dabble, 4 bits
//   per conversion step, then the digits are scanned one per cycle from
//   the least significant end until none remain, then the classify step
//   loads the result register.
//   One item is in work at a time; o_in_ready is high only when idle.
// Stalls:
//   A result waiting in the output register does not block the next input;
//   the block holds in the classify step only if the previous result is
//   still not taken when the next one is ready.
// Reset:
//   Synchronous, active low; returns to idle with no result pending.
// ----------------------------------------------------------------------------
module luhn_card_number_check_top
    import luhn_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [CARD_W-1:0]  i_card_number,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [BRAND_W-1:0] o_brand,
    output logic               o_luhn_ok,
    output logic [COUNT_W-1:0] o_digit_count
);

    t_dp_cmd    cmd;
    t_dp_status status;

    luhn_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    luhn_dp u_dp (
        .i_clk         (i_clk),
        .i_card_number (i_card_number),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_brand       (o_brand),
        .o_luhn_ok     (o_luhn_ok),
        .o_digit_count (o_digit_count)
    );

    // A valid brand always comes with a passing checksum
    a_brand_needs_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_brand != BRAND_NONE |-> o_luhn_ok)
        else $error("brand reported without passing checksum");

    // The four-prefix brand code matches its digit counts
    a_brand_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_brand == BRAND_FOUR |->
            (o_digit_count == 5'd13 || o_digit_count == 5'd16))
        else $error("four-prefix brand with wrong digit count");

    // Digit count stays within the range of a 63-bit number
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_digit_count <= 5'd19)
        else $error("digit count out of range");

    // An accepted transaction keeps the block busy in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready && cmd.conv)
        else $error("controller did not start conversion");

endmodule

// ===== design/luhn_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// luhn_ctrl
// Sequencer: conversion steps, digit scan, classify, and the result slot.
// ----------------------------------------------------------------------------
module luhn_ctrl
    import luhn_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state                r_state, n_state;
    logic [STEP_CNT_W-1:0] r_step,  n_step;
    logic                  r_out_valid, n_out_valid;
    logic                  slot_free;

    // Result slot can take a new result when empty or being drained
    assign slot_free = !r_out_valid || i_out_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        case (r_state)
            S_IDLE: begin
                n_step = '0;
                if (i_in_valid) begin
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                n_step = r_step + 1'b1;
                if (r_step == STEP_CNT_W'(CONV_STEPS - 1)) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_status.bcd_zero) begin
                    n_state = S_CLASS;
                end
            end
            S_CLASS: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Outputs / commands
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_CONV: begin
                o_cmd.conv = 1'b1;
            end
            S_SCAN: begin
                o_cmd.scan = !i_status.bcd_zero;
            end
            S_CLASS: begin
                o_cmd.emit = slot_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    // Result valid flag
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== design/luhn_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// luhn_dp
// Binary to BCD conversion, digit-serial Luhn sum, classification, result.
// ----------------------------------------------------------------------------
module luhn_dp
    import luhn_pkg::*;
(
    input  logic                i_clk,
    input  logic [CARD_W-1:0]   i_card_number,
    input  t_dp_cmd             i_cmd,
    output t_dp_status          o_status,
    output logic [BRAND_W-1:0]  o_brand,
    output logic                o_luhn_ok,
    output logic [COUNT_W-1:0]  o_digit_count
);

    logic [BIN_W-1:0]   r_bin;
    logic [BCD_W-1:0]   r_bcd;
    logic [DIGIT_W-1:0] r_sum;      // running sum mod 10
    logic [COUNT_W-1:0] r_count;
    logic [DIGIT_W-1:0] r_lead;
    logic [DIGIT_W-1:0] r_second;
    logic [BRAND_W-1:0] r_brand;
    logic               r_luhn_ok;
    logic [COUNT_W-1:0] r_digit_count;

    logic [BCD_W-1:0]   n_bcd_conv;
    logic [DIGIT_W-1:0] dig;
    logic [DIGIT_W:0]   dbl;
    logic [DIGIT_W-1:0] weight;
    logic [DIGIT_W:0]   sum_raw;
    logic [DIGIT_W-1:0] n_sum;
    logic               ok;
    logic [BRAND_W-1:0] brand;

    // Four double-dabble bits per cycle, MSB first
    always_comb begin
        n_bcd_conv = r_bcd;
        for (int k = 0; k < BITS_PER_STEP; k++) begin
            n_bcd_conv = dabble_bit(n_bcd_conv, r_bin[BIN_W-1-k]);
        end
    end

    // Weight of lowest digit: odd positions as is, even positions doubled
    assign dig = r_bcd[DIGIT_W-1:0];
    assign dbl = {dig, 1'b0};
    always_comb begin
        if (!r_count[0]) begin
            weight = dig;
        end else if (dbl > 5'd9) begin
            weight = DIGIT_W'(dbl - 5'd9);
        end else begin
            weight = dbl[DIGIT_W-1:0];
        end
        sum_raw = {1'b0, r_sum} + {1'b0, weight};
        n_sum   = (sum_raw >= 5'd10) ? DIGIT_W'(sum_raw - 5'd10)
                                     : sum_raw[DIGIT_W-1:0];
    end

    // Checksum result, and brand from leading digits and count when it passes
    assign ok = (r_sum == 4'd0);
    always_comb begin
        brand = BRAND_NONE;
        if (ok) begin
            if (r_lead == 4'd4 && (r_count == 5'd13 || r_count == 5'd16)) begin
                brand = BRAND_FOUR;
            end else if (r_lead == 4'd5 && r_second >= 4'd1 && r_second <= 4'd5
                         && r_count == 5'd16) begin
                brand = BRAND_FIFTY;
            end else if (r_lead == 4'd3 && (r_second == 4'd4 || r_second == 4'd7)
                         && r_count == 5'd15) begin
                brand = BRAND_THIRTY;
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_bin    <= {1'b0, i_card_number};
            r_bcd    <= '0;
            r_sum    <= '0;
            r_count  <= '0;
            r_lead   <= '0;
            r_second <= '0;
        end else if (i_cmd.conv) begin
            r_bin <= r_bin << BITS_PER_STEP;
            r_bcd <= n_bcd_conv;
        end else if (i_cmd.scan) begin
            r_bcd    <= r_bcd >> DIGIT_W;
            r_sum    <= n_sum;
            r_count  <= r_count + 1'b1;
            r_second <= r_lead;
            r_lead   <= dig;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_brand       <= brand;
            r_luhn_ok     <= ok;
            r_digit_count <= r_count;
        end
    end

    assign o_status.bcd_zero = (r_bcd == '0);
    assign o_brand           = r_brand;
    assign o_luhn_ok         = r_luhn_ok;
    assign o_digit_count     = r_digit_count;

endmodule
